### rtl/pde_pkg.sv
// Shared types, widths and constants of the timestamp duration estimator.
// Used by every module under rtl; depends on nothing else.
package pde_pkg;

	localparam int PTS_W       = 64;
	localparam int RATE_W      = 32;
	localparam int CNT_W       = 32;
	localparam int IVL_W       = 63;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 224;

	// Input stream layout.
	localparam int IN_RESTART_BIT = 0;
	localparam int IN_PTS_LSB     = 1;
	localparam int IN_RATE_LSB    = 65;

	// Output stream layout.
	localparam int OUT_ACC_BIT     = 0;
	localparam int OUT_TOTAL_LSB   = 1;
	localparam int OUT_LARGEST_LSB = 33;
	localparam int OUT_IVL_LSB     = 97;
	localparam int OUT_DUR_LSB     = 160;
	localparam int OUT_DVALID_BIT  = 223;

	// A whole quotient of 2^44 or more always overflows once scaled to microseconds.
	localparam int QUO_BITS  = 44;
	localparam int FRAC_BITS = 20;
	localparam int STEP_CNT_W = 6;
	localparam logic [FRAC_BITS-1:0] US_PER_SEC = 20'd1000000;
	localparam logic [QUO_BITS-1:0]  WHOLE_MAX  = 44'd9223372036854;
	localparam logic [PTS_W-1:0]     NEG_LIMIT  = 64'h8000_0000_0000_0000;
	localparam logic [CNT_W-1:0]     COUNT_MAX  = 32'hFFFF_FFFF;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Classified item handed from the front end to the converter.
	typedef struct packed {
		logic              restart;
		logic              sign;
		logic              reject;
		logic [PTS_W-1:0]  mag;
		logic [RATE_W-1:0] rate;
	} item_t;

	// Converted timestamp handed to the statistics unit.
	typedef struct packed {
		logic             restart;
		logic             ok;
		logic [PTS_W-1:0] us;
	} conv_res_t;

	typedef enum logic [7:0] {
		CNV_IDLE = 8'b0000_0001,
		CNV_QUO  = 8'b0000_0010,
		CNV_REM  = 8'b0000_0100,
		CNV_FRAC = 8'b0000_1000,
		CNV_MUL  = 8'b0001_0000,
		CNV_SUM  = 8'b0010_0000,
		CNV_SIGN = 8'b0100_0000,
		CNV_DONE = 8'b1000_0000
	} cnv_state_t;

endpackage

### rtl/pts_duration_estimator_top.sv
// Timestamp duration estimator: converts each timestamp to microseconds and keeps
// running statistics that give a duration estimate for every input transfer.
//
// Channels: the s_ stream carries one sample per transfer (restart flag, signed
// 64-bit timestamp, 32-bit tick rate); the m_ stream returns exactly one result
// per sample (accepted flag, sample count, largest timestamp, smallest interval,
// duration and its valid flag), in input order.
// Conversion: a sample that passes the early check runs through the converter's
// shared divider step (44 whole-quotient bits and 20 fraction bits, one bit a
// cycle) and then its scale, add and sign steps. A sample with a zero tick rate
// or an oversized quotient skips these steps. The converter takes no new sample
// until its result has been taken, and the statistics unit takes no new result
// until its update has reached the result register.
// A two-entry queue after the input register lets the input side keep taking
// samples while the converter or the output side is busy; when the receiver
// stalls, the result register holds and back pressure reaches s_tready only once
// the queue and input register are full.
// Reset clears all statistics and leaves both streams empty.
module pts_duration_estimator_top import pde_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // restart, pts_value[63:0], tick_rate[31:0], zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // accepted, sample_total[31:0], largest_us[63:0],
	                                         // interval_us[62:0], duration_us[62:0], duration_valid
);

	logic      push_valid;
	logic      push_ready;
	item_t     push_item;
	logic      pop_valid;
	logic      pop_ready;
	item_t     pop_item;
	logic      cnv_valid;
	logic      cnv_ready;
	conv_res_t cnv_res;

	pde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	pde_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	pde_convert u_convert (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.res_valid  (cnv_valid),
		.res_ready  (cnv_ready),
		.res        (cnv_res)
	);

	pde_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (cnv_valid),
		.res_ready (cnv_ready),
		.res       (cnv_res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// A counted sample always leaves a nonzero sample total.
	a_accepted_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_ACC_BIT] |-> m_tdata[OUT_TOTAL_LSB +: CNT_W] != '0)
		else $error("accepted result with zero sample total");

	// A valid estimate needs at least two samples.
	a_valid_two_samples: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_DVALID_BIT] |-> m_tdata[OUT_TOTAL_LSB +: CNT_W] >= CNT_W'(2))
		else $error("duration valid with fewer than two samples");

	// The duration is nonzero exactly when the estimate is valid.
	a_duration_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DVALID_BIT] == (m_tdata[OUT_DUR_LSB +: IVL_W] != '0))
		else $error("duration value disagrees with its valid flag");

endmodule

### rtl/pde_front.sv
// Input stage: registers one stream transfer and classifies it (sign, magnitude,
// early reject) for the item queue. Depends on pde_pkg.
module pde_front import pde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // restart, pts_value[63:0], tick_rate[31:0], zero pad
	output logic                  push_valid,
	input  logic                  push_ready,
	output item_t                 push_item
);

	logic              hold_valid_q;
	logic              restart_q;
	logic [PTS_W-1:0]  pts_q;
	logic [RATE_W-1:0] rate_q;
	logic [PTS_W-1:0]  mag;

	assign s_tready   = !hold_valid_q || push_ready;
	assign push_valid = hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (s_tready) begin
			hold_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			restart_q <= s_tdata[IN_RESTART_BIT];
			pts_q     <= s_tdata[IN_PTS_LSB +: PTS_W];
			rate_q    <= s_tdata[IN_RATE_LSB +: RATE_W];
		end
	end

	// The most negative timestamp has magnitude 2^63, which still fits unsigned.
	assign mag = pts_q[PTS_W-1] ? (~pts_q + PTS_W'(1)) : pts_q;

	always_comb begin
		push_item.restart = restart_q;
		push_item.sign    = pts_q[PTS_W-1];
		push_item.mag     = mag;
		push_item.rate    = rate_q;
		push_item.reject  = (rate_q == '0) ||
			(RATE_W'(mag[PTS_W-1:QUO_BITS]) >= rate_q);
	end

endmodule

### rtl/pde_queue.sv
// Short flip-flop queue of classified items between the front end and the
// converter. Depends on pde_pkg.
module pde_queue import pde_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t                  entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/pde_convert.sv
// Converter: one shared restoring divider step runs the whole quotient and the
// scaled remainder, then scales, adds and range checks. Depends on pde_pkg.
module pde_convert import pde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  item_t     item,
	output logic      res_valid,
	input  logic      res_ready,
	output conv_res_t res
);

	cnv_state_t            state_q;
	logic [STEP_CNT_W-1:0] cnt_q;

	logic [RATE_W-1:0]    rate_q;
	logic [RATE_W-1:0]    rem_q;
	logic [QUO_BITS-1:0]  dvd_q;
	logic [QUO_BITS-1:0]  quo_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [PTS_W-1:0]     prod_q;
	logic [PTS_W-1:0]     sum_q;
	logic                 big_q;
	logic                 sign_q;
	logic                 restart_q;
	logic                 ok_q;
	logic [PTS_W-1:0]     us_q;

	logic [RATE_W:0]                trial;
	logic                           step_ge;
	logic [RATE_W:0]                trial_sub;
	logic [RATE_W-1:0]              rem_next;
	logic [RATE_W+FRAC_BITS-1:0]    rem_scaled;
	logic                           take;

	assign item_ready = (state_q == CNV_IDLE);
	assign take       = item_valid && item_ready;
	assign res_valid  = (state_q == CNV_DONE);

	assign res.restart = restart_q;
	assign res.ok      = ok_q;
	assign res.us      = us_q;

	// One quotient bit per cycle; the partial remainder always stays below the rate.
	assign trial      = {rem_q, dvd_q[QUO_BITS-1]};
	assign step_ge    = (trial >= {1'b0, rate_q});
	assign trial_sub  = trial - {1'b0, rate_q};
	assign rem_next   = step_ge ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
	assign rem_scaled = (RATE_W+FRAC_BITS)'(rem_q) * (RATE_W+FRAC_BITS)'(US_PER_SEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CNV_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				CNV_IDLE: begin
					if (take) begin
						state_q <= item.reject ? CNV_DONE : CNV_QUO;
						cnt_q   <= STEP_CNT_W'(QUO_BITS - 1);
					end
				end
				CNV_QUO: begin
					if (cnt_q == '0) begin
						state_q <= CNV_REM;
					end else begin
						cnt_q <= cnt_q - STEP_CNT_W'(1);
					end
				end
				CNV_REM: begin
					state_q <= CNV_FRAC;
					cnt_q   <= STEP_CNT_W'(FRAC_BITS - 1);
				end
				CNV_FRAC: begin
					if (cnt_q == '0) begin
						state_q <= CNV_MUL;
					end else begin
						cnt_q <= cnt_q - STEP_CNT_W'(1);
					end
				end
				CNV_MUL:  state_q <= CNV_SUM;
				CNV_SUM:  state_q <= CNV_SIGN;
				CNV_SIGN: state_q <= CNV_DONE;
				CNV_DONE: begin
					if (res_ready) begin
						state_q <= CNV_IDLE;
					end
				end
				default: state_q <= CNV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CNV_IDLE: begin
				if (take) begin
					restart_q <= item.restart;
					sign_q    <= item.sign;
					rate_q    <= item.rate;
					rem_q     <= RATE_W'(item.mag[PTS_W-1:QUO_BITS]);
					dvd_q     <= item.mag[QUO_BITS-1:0];
					ok_q      <= 1'b0;
					us_q      <= '0;
				end
			end
			CNV_QUO: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[QUO_BITS-2:0], 1'b0};
				quo_q <= {quo_q[QUO_BITS-2:0], step_ge};
			end
			CNV_REM: begin
				// The scaled remainder over the rate is below 2^20, so its top part
				// already starts below the rate.
				rem_q <= rem_scaled[RATE_W+FRAC_BITS-1:FRAC_BITS];
				dvd_q <= {rem_scaled[FRAC_BITS-1:0], (QUO_BITS-FRAC_BITS)'(0)};
			end
			CNV_FRAC: begin
				rem_q  <= rem_next;
				dvd_q  <= {dvd_q[QUO_BITS-2:0], 1'b0};
				frac_q <= {frac_q[FRAC_BITS-2:0], step_ge};
			end
			CNV_MUL: begin
				prod_q <= PTS_W'(quo_q) * PTS_W'(US_PER_SEC);
				big_q  <= (quo_q > WHOLE_MAX);
			end
			CNV_SUM: begin
				sum_q <= prod_q + PTS_W'(frac_q);
			end
			CNV_SIGN: begin
				ok_q <= !big_q && (sign_q ? (sum_q <= NEG_LIMIT) : !sum_q[PTS_W-1]);
				us_q <= sign_q ? (~sum_q + PTS_W'(1)) : sum_q;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/pde_stats.sv
// Statistics unit: applies restart, updates count, largest timestamp and smallest
// interval, and holds the output result register. Depends on pde_pkg.
module pde_stats import pde_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   res_valid,
	output logic                   res_ready,
	input  conv_res_t              res,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [PTS_W-1:0] prev_q;
	logic             prev_present_q;
	logic [PTS_W-1:0] max_q;
	logic             max_present_q;
	logic [IVL_W-1:0] min_q;
	logic [CNT_W-1:0] count_q;

	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             ok_s1;
	logic [PTS_W-1:0] us_s1;
	logic [PTS_W:0]   diff_s2;
	logic             gt_s2;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [PTS_W:0]   gap;
	logic             gap_take;
	logic [IVL_W-1:0] base;
	logic [PTS_W-1:0] base_sum;
	logic             dur_valid;
	logic [IVL_W-1:0] dur;
	logic             out_load;

	assign res_ready = !(v_s1 || v_s2 || v_s3);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign out_load  = v_s3 && (!out_valid_q || m_tready);

	assign gap      = diff_s2[PTS_W] ? (~diff_s2 + (PTS_W+1)'(1)) : diff_s2;
	assign gap_take = prev_present_q && (diff_s2 != '0) && (gap[PTS_W:IVL_W] == '0) &&
		((min_q == '0) || (gap[IVL_W-1:0] < min_q));

	// Only a positive largest timestamp adds to the base.
	assign base      = max_q[PTS_W-1] ? '0 : max_q[IVL_W-1:0];
	assign base_sum  = {1'b0, base} + {1'b0, min_q};
	assign dur_valid = (count_q >= CNT_W'(2)) && max_present_q && (min_q != '0);
	assign dur       = !dur_valid ? '0 : (base_sum[PTS_W-1] ? base : base_sum[IVL_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			out_valid_q    <= 1'b0;
			prev_q         <= '0;
			prev_present_q <= 1'b0;
			max_q          <= '0;
			max_present_q  <= 1'b0;
			min_q          <= '0;
			count_q        <= '0;
		end else begin
			if (res_valid && res_ready) begin
				v_s1 <= 1'b1;
				if (res.restart) begin
					prev_q         <= '0;
					prev_present_q <= 1'b0;
					max_q          <= '0;
					max_present_q  <= 1'b0;
					min_q          <= '0;
					count_q        <= '0;
				end
			end else if (v_s1) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b1;
			end else if (v_s2) begin
				v_s2 <= 1'b0;
				v_s3 <= 1'b1;
				if (ok_s1) begin
					if (count_q != COUNT_MAX) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (gap_take) begin
						min_q <= gap[IVL_W-1:0];
					end
					prev_q         <= us_s1;
					prev_present_q <= 1'b1;
					if (!max_present_q || gt_s2) begin
						max_q         <= us_s1;
						max_present_q <= 1'b1;
					end
				end
			end else if (out_load) begin
				v_s3 <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			ok_s1 <= res.ok;
			us_s1 <= res.us;
		end
		if (v_s1) begin
			diff_s2 <= {us_s1[PTS_W-1], us_s1} - {prev_q[PTS_W-1], prev_q};
			gt_s2   <= $signed(us_s1) > $signed(max_q);
		end
		if (out_load) begin
			out_data_q[OUT_ACC_BIT]                <= ok_s1;
			out_data_q[OUT_TOTAL_LSB +: CNT_W]     <= count_q;
			out_data_q[OUT_LARGEST_LSB +: PTS_W]   <= max_present_q ? max_q : '0;
			out_data_q[OUT_IVL_LSB +: IVL_W]       <= min_q;
			out_data_q[OUT_DUR_LSB +: IVL_W]       <= dur;
			out_data_q[OUT_DVALID_BIT]             <= dur_valid;
		end
	end

endmodule

### test/tb.sv
// Self-checking testbench for pts_duration_estimator_top: drives timestamp samples on the
// input stream, predicts every result and checks the output stream field by field.
// Depends on rtl/pde_pkg.sv and rtl/pts_duration_estimator_top.sv.
module tb import pde_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
	localparam longint US_SEC = 1000000;
	localparam longint WHOLE_HI = I64_MAX / US_SEC;
	localparam longint WHOLE_LO = I64_MIN / US_SEC;
	localparam logic [63:0] GAP_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] TOTAL_SAT = 32'hFFFF_FFFF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic              dvalid;
		logic [IVL_W-1:0]  dur;
		logic [IVL_W-1:0]  ivl;
		logic [PTS_W-1:0]  largest;
		logic [CNT_W-1:0]  total;
		logic              acc;
	} sample_report_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // restart, pts_value[63:0], tick_rate[31:0], zero pad
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // accepted, sample_total[31:0], largest_us[63:0],
	                                   // interval_us[62:0], duration_us[62:0], duration_valid

	// Predicted statistics of the estimator.
	longint      prev_us;
	bit          prev_valid;
	longint      peak_us;
	bit          peak_valid;
	logic [63:0] min_gap;
	logic [31:0] seen_total;

	sample_report_t pending_results[$];
	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int cycles;

	pts_duration_estimator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit convert_to_us(longint ts, logic [31:0] rate, output longint us);
		longint scale, whole, rem, frac, scaled;
		us = 0;
		if (rate == 0)
			return 0;
		scale = longint'({32'd0, rate});
		whole = ts / scale;
		rem = ts % scale;
		if (whole > WHOLE_HI || whole < WHOLE_LO)
			return 0;
		scaled = whole * US_SEC;
		frac = rem * US_SEC / scale;
		if ((frac > 0 && scaled > I64_MAX - frac) || (frac < 0 && scaled < I64_MIN - frac))
			return 0;
		us = scaled + frac;
		return 1;
	endfunction

	function automatic void clear_stats();
		prev_us = 0;
		prev_valid = 0;
		peak_us = 0;
		peak_valid = 0;
		min_gap = '0;
		seen_total = '0;
	endfunction

	function automatic sample_report_t estimate_duration(bit restart, longint ts,
			logic [31:0] rate);
		sample_report_t r;
		longint us;
		bit ok, valid;
		logic [63:0] d, base;
		if (restart)
			clear_stats();
		ok = convert_to_us(ts, rate, us);
		if (ok) begin
			if (seen_total != TOTAL_SAT)
				seen_total++;
			if (prev_valid && us != prev_us) begin
				d = (us > prev_us) ? 64'(us) - 64'(prev_us) : 64'(prev_us) - 64'(us);
				if (d <= GAP_LIMIT && (min_gap == 0 || d < min_gap))
					min_gap = d;
			end
			prev_us = us;
			prev_valid = 1;
			if (!peak_valid || us > peak_us) begin
				peak_us = us;
				peak_valid = 1;
			end
		end
		valid = seen_total >= 2 && peak_valid && min_gap != 0;
		base = '0;
		if (valid) begin
			base = (peak_us > 0) ? 64'(peak_us) : 64'd0;
			// The interval is dropped when adding it would leave the signed range.
			if (base <= GAP_LIMIT - min_gap)
				base += min_gap;
		end
		r.acc = ok;
		r.total = seen_total;
		r.largest = peak_valid ? peak_us : 64'd0;
		r.ivl = min_gap[IVL_W-1:0];
		r.dur = base[IVL_W-1:0];
		r.dvalid = valid;
		return r;
	endfunction

	// The sender only lowers tvalid when it idles, so a held tvalid never toggles in one step.
	task automatic send_sample(bit restart, longint ts, logic [31:0] rate);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, rate, ts, restart};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(estimate_duration(restart, ts, rate));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
			return 0;
		end
		return 1;
	endfunction

	always @(posedge clk) begin : result_check
		sample_report_t got, want;
		bit bad;
		if (arst_n && m_tvalid && m_tready) begin
			got.acc = m_tdata[OUT_ACC_BIT];
			got.total = m_tdata[OUT_TOTAL_LSB +: CNT_W];
			got.largest = m_tdata[OUT_LARGEST_LSB +: PTS_W];
			got.ivl = m_tdata[OUT_IVL_LSB +: IVL_W];
			got.dur = m_tdata[OUT_DUR_LSB +: IVL_W];
			got.dvalid = m_tdata[OUT_DVALID_BIT];
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("result transfer with nothing pending: %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				bad = 0;
				bad |= !field_ok("accepted", want.acc, got.acc);
				bad |= !field_ok("sample_total", want.total, got.total);
				bad |= !field_ok("largest_us", want.largest, got.largest);
				bad |= !field_ok("interval_us", want.ivl, got.ivl);
				bad |= !field_ok("duration_us", want.dur, got.dur);
				bad |= !field_ok("duration_valid", want.dvalid, got.dvalid);
				if (bad)
					mismatches++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("pts_duration_estimator_top regression: fail");
			$finish;
		end
	end

	// Conversion limits, rejection paths, restart and the corner cases of the estimate.
	task automatic test_conversion_edges();
		longint near_hi;
		near_hi = WHOLE_HI * 999999 + 999998;
		send_sample(0, 0, 0);
		send_sample(0, 1000, 1000);
		send_sample(0, 1000, 1000);            // equal timestamps give no distance
		send_sample(0, 1040, 1000);
		send_sample(0, -9000, 90000);
		send_sample(0, I64_MAX, 1);            // whole quotient too large
		send_sample(0, I64_MIN, 1);
		send_sample(0, near_hi, 999999);       // overflow only once the fraction is added
		send_sample(0, -near_hi, 999999);
		send_sample(1, 12345, 0);              // restart on a rejected sample
		send_sample(1, I64_MIN, 1000000);      // lands exactly on the most negative value
		send_sample(0, I64_MAX, 1000000);      // distance beyond the signed range
		send_sample(0, I64_MAX - 10, 1000000); // interval cannot be added to the maximum
		send_sample(0, -1, 32'hFFFF_FFFF);
		send_sample(0, I64_MAX, 32'hFFFF_FFFF);
		send_sample(1, 5, 1);
		send_sample(0, -3, 7);
		send_sample(0, 6, 1);
		send_sample(0, 7, 1);
		send_sample(0, 0, 1);
	endtask

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 7))
			0: return 32'd90000;
			1: return 32'd1000;
			2: return 32'd48000;
			3: return 32'd44100;
			4: return 32'd1000000;
			5: return 32'd27000000;
			6: return $urandom_range(1, 100);
			default: return $urandom_range(32'hFFFF_FFFF, 1);
		endcase
	endfunction

	// Mostly runs of frame timestamps with random content, the rest is raw noise.
	task automatic test_random_traffic(int items, int s_pct, int r_pct);
		int sent, run_len;
		bit paused, restart;
		longint ts, step;
		logic [31:0] rate;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		paused = 0;
		while (sent < items) begin
			if (!paused && sent >= items / 2) begin
				paused = 1;
				wait_results_drained();
			end
			if ($urandom_range(99) < 20) begin
				case ($urandom_range(0, 3))
					0: rate = '0;
					1: rate = $urandom_range(1, 16);
					default: rate = $urandom;
				endcase
				send_sample(1'($urandom_range(1)), {$urandom, $urandom}, rate);
				sent++;
			end else begin
				rate = pick_rate();
				step = longint'($urandom_range(1, 5000));
				case ($urandom_range(0, 7))
					0: begin
						rate = 32'd1000000;
						ts = I64_MAX - step * longint'($urandom_range(0, 40));
					end
					1: begin
						rate = 32'd1000000;
						ts = I64_MIN + step * longint'($urandom_range(0, 40));
					end
					2: ts = longint'({$urandom, $urandom}) >>> $urandom_range(20, 40);
					default: ts = longint'($urandom_range(0, 200000)) - 100000;
				endcase
				run_len = $urandom_range(3, 30);
				for (int k = 0; k < run_len && sent < items; k++) begin
					restart = (k == 0) && ($urandom_range(1) == 1);
					case ($urandom_range(0, 9))
						0: ;
						1: ts = ts - step * longint'($urandom_range(1, 3));
						default: ts = ts + step;
					endcase
					send_sample(restart, ts, rate);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		send_idle_pct = 18;
		recv_idle_pct = 58;
		mismatches = 0;
		cycles = 0;
		clear_stats();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_conversion_edges();
		test_random_traffic(580, 18, 58);
		test_random_traffic(580, 58, 18);
		test_random_traffic(580, 0, 0);

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("pts_duration_estimator_top regression: pass");
		end else begin
			$display("pts_duration_estimator_top regression: fail");
		end
		$finish;
	end

endmodule
